### rtl/core/bhm_pkg.sv
`timescale 1ns / 1ps
package bhm_pkg;

  localparam int LBA_W        = 48;
  localparam int SPB_W        = 17;
  localparam int WORDS_W      = 11;
  localparam int WIDX_W       = 10;
  localparam int WORD_W       = 64;
  localparam int BLK_SHIFT    = 5;
  localparam int CFG_IDX_W    = 2;
  localparam int CNT_W        = 32;
  localparam int MASK_WORDS_D = 1024;

  localparam logic [1:0] OP_REPAIR = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [2:0] IO_OK    = 3'd0;
  localparam logic [2:0] IO_NOMEM = 3'd1;
  localparam logic [2:0] IO_INVAL = 3'd2;
  localparam logic [2:0] IO_GEOM  = 3'd3;
  localparam logic [2:0] IO_PHYS  = 3'd4;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_MEDIA_TOXIC = 3'd4;

  localparam logic [1:0] H_TOXIC  = 2'd0;
  localparam logic [1:0] H_BRONZE = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_MASK_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTORS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_WORDS  = 2'd2;

  localparam logic               ENABLE_RST  = 1'b1;
  localparam logic [SPB_W-1:0]   SECTORS_RST = 17'd8;
  localparam logic [WORDS_W-1:0] WORDS_RST   = 11'd1024;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [LBA_W-1:0]  lba;
    logic [2:0]        io_status;
    logic [WIDX_W-1:0] word_index;
    logic [WORD_W-1:0] word_data;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [1:0]        prior_health;
    logic [1:0]        next_health;
    logic              mask_hit;
    logic [WORD_W-1:0] read_word;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic mem_rd;
    logic finish;
    logic clear_step;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       enable;
    logic       widx_ok;
    logic       in_range;
    logic       div_done;
    logic       clear_last;
    logic       rsp_free;
  } sts_t;

endpackage

### rtl/core/bhm_div.sv
`timescale 1ns / 1ps
module bhm_div import bhm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [LBA_W-1:0] dividend,
  input  logic [SPB_W-1:0] divisor,
  output logic [LBA_W-1:0] quotient,
  output logic             done
);

  localparam int STEP_W = $clog2(LBA_W);

  logic [SPB_W-1:0]  rem;
  logic [SPB_W-1:0]  dsr;
  logic [LBA_W-1:0]  quo;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic [SPB_W:0]    partial;
  logic [SPB_W:0]    trial;

  assign partial  = {rem, quo[LBA_W-1]};
  assign trial    = partial - {1'b0, dsr};
  assign quotient = quo;

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
      rem  <= '0;
      quo  <= dividend;
      dsr  <= (divisor == '0) ? SPB_W'(1) : divisor;
    end else if (busy) begin
      if (!trial[SPB_W]) begin
        rem <= trial[SPB_W-1:0];
        quo <= {quo[LBA_W-2:0], 1'b1};
      end else begin
        rem <= partial[SPB_W-1:0];
        quo <= {quo[LBA_W-2:0], 1'b0};
      end
      if (step == STEP_W'(LBA_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
      step <= step + STEP_W'(1);
    end
  end

endmodule

### rtl/core/bhm_dp.sv
`timescale 1ns / 1ps
module bhm_dp import bhm_pkg::*; #(
  parameter int MASK_WORDS = MASK_WORDS_D
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  req_t                 req,
  output rsp_t                 rsp,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SPB_W-1:0]     cfg_data
);

  localparam int AW     = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1;
  localparam int WN_W   = LBA_W - BLK_SHIFT;
  localparam int WIDE_W = 17;

  logic [WORD_W-1:0] mem [MASK_WORDS];
  logic [WORD_W-1:0] rdata;

  req_t              item;
  logic              mask_enable;
  logic [SPB_W-1:0]  sectors;
  logic [WORDS_W-1:0] words;
  logic [AW-1:0]     clr_addr;
  logic [CNT_W-1:0]  heal_counter;
  logic [CNT_W-1:0]  toxic_counter;

  logic [LBA_W-1:0]  quotient;
  logic              div_done;
  logic [WN_W-1:0]   word_num;
  logic [4:0]        slot;
  logic              in_range;
  logic [WIDE_W-1:0] widx_ext;
  logic              widx_ok;
  logic [AW-1:0]     word_addr;
  logic [AW-1:0]     widx_addr;

  logic              hit;
  logic              ok;
  logic              abstain;
  logic              fail;
  logic [1:0]        prior;
  logic [1:0]        next_h;
  logic              change;
  logic [2:0]        res;
  logic [2:0]        status;
  logic [WORD_W-1:0] wnew;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;

  bhm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (item.lba),
    .divisor  (sectors),
    .quotient (quotient),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_enable <= ENABLE_RST;
      sectors     <= SECTORS_RST;
      words       <= WORDS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MASK_ENABLE: mask_enable <= cfg_data[0];
        CFG_SECTORS:     sectors     <= cfg_data;
        CFG_MASK_WORDS:  words       <= cfg_data[WORDS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item <= req;
  end

  assign word_num  = quotient[LBA_W-1:BLK_SHIFT];
  assign slot      = quotient[BLK_SHIFT-1:0];
  assign in_range  = (word_num < WN_W'(words)) && (word_num < WN_W'(MASK_WORDS));
  assign widx_ext  = WIDE_W'(item.word_index);
  assign widx_ok   = widx_ext < WIDE_W'(MASK_WORDS);
  assign word_addr = word_num[AW-1:0];
  assign widx_addr = widx_ext[AW-1:0];

  always_comb begin
    ok      = (item.io_status == IO_OK);
    abstain = (item.io_status == IO_NOMEM) || (item.io_status == IO_INVAL);
    fail    = !ok && !abstain;
    hit     = (item.opcode == OP_REPAIR) && mask_enable && in_range;
    prior   = hit ? rdata[{slot, 1'b0} +: 2] : H_TOXIC;
    if (prior == H_TOXIC || abstain) next_h = prior;
    else if (ok)                     next_h = H_BRONZE;
    else                             next_h = H_TOXIC;
    change  = hit && (next_h != prior);
    wnew    = rdata;
    wnew[{slot, 1'b0} +: 2] = next_h;
    res     = item.io_status;
    // success on a toxic block
    if (hit && !change && prior == H_TOXIC && ok) res = ST_MEDIA_TOXIC;
    if (item.opcode != OP_REPAIR)  status = ST_OK;
    else if (res == IO_OK)         status = ST_OK;
    else if (res <= IO_GEOM)       status = res;
    else                           status = ST_MEDIA_TOXIC;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '1;
    if (cmd.clear_step) begin
      mem_we = 1'b1;
    end else if (cmd.finish && item.opcode == OP_WRITE && widx_ok) begin
      mem_we    = 1'b1;
      mem_waddr = widx_addr;
      mem_wdata = item.word_data;
    end else if (cmd.finish && change) begin
      mem_we    = 1'b1;
      mem_waddr = word_addr;
      mem_wdata = wnew;
    end
    mem_raddr = (item.opcode == OP_READ) ? widx_addr : word_addr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd.mem_rd) rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heal_counter  <= '0;
      toxic_counter <= '0;
    end else if (cmd.finish && item.opcode == OP_REPAIR) begin
      if (res == IO_OK) heal_counter <= heal_counter + CNT_W'(1);
      if (res >= IO_PHYS && change && fail) toxic_counter <= toxic_counter + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp.status       <= status;
      rsp.prior_health <= prior;
      rsp.next_health  <= next_h;
      rsp.mask_hit     <= hit;
      rsp.read_word    <= (item.opcode == OP_READ && widx_ok) ? rdata : '0;
    end
  end

  assign sts.op         = item.opcode;
  assign sts.enable     = mask_enable;
  assign sts.widx_ok    = widx_ok;
  assign sts.in_range   = in_range;
  assign sts.div_done   = div_done;
  assign sts.clear_last = (clr_addr == AW'(MASK_WORDS - 1));
  assign sts.rsp_free   = !rsp_valid || rsp_ready;

  a_hit_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.mask_hit |-> rsp.prior_health == H_TOXIC && rsp.next_health == H_TOXIC)
    else $error("skipped update carries health values");

  a_lower_only: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.next_health != rsp.prior_health
      |-> rsp.next_health == H_TOXIC || rsp.next_health == H_BRONZE)
    else $error("health raised by a report");

  a_sticky: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.mask_hit && rsp.prior_health == H_TOXIC |-> rsp.next_health == H_TOXIC)
    else $error("toxic slot left toxic state");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mem_rd && (cmd.finish || cmd.clear_step)))
    else $error("read issued together with a write command");

endmodule

### rtl/core/bhm_ctrl.sv
`timescale 1ns / 1ps
module bhm_ctrl import bhm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.op == OP_REPAIR && sts.enable) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else if (sts.op == OP_READ && sts.widx_ok) begin
          state_next = S_READ;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_next = sts.in_range ? S_READ : S_FIN;
      end
      S_READ: begin
        cmd.mem_rd = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (sts.rsp_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  assign req_ready = (state == S_IDLE);

endmodule

### rtl/core/block_health_mask_update.sv
`timescale 1ns / 1ps
// channel  signals                                   width
// req      req_valid, req_ready, req (req_t)         127
// rsp      rsp_valid, rsp_ready, rsp (rsp_t)         72
// cfg      cfg_valid, cfg_ready, cfg_index, cfg_data 2 + 17
//
// repair report: decode, 48-step serial divider, one store read, then the final state
// writes the modified word back on a change; a word past the mask skips the read; write,
// read and disabled mask skip the divider; after reset a clearing pass sets all MASK_WORDS
// words to gold, one word a cycle, so req_ready stays low until it ends; cfg is always ready
// a finished result sits in the output register; a stalled rsp holds the
// next item in its final cycle until that register frees
module block_health_mask_update import bhm_pkg::*; #(
  parameter int MASK_WORDS = MASK_WORDS_D
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output rsp_t                 rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SPB_W-1:0]     cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  bhm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bhm_dp #(
    .MASK_WORDS (MASK_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
